/* hdl/mhfp_pkg.sv */
// Package for the message header field parser.
// Holds the transfer payload types, field type codes, result kinds and parser phase codes.
// No dependencies.
package mhfp_pkg;

    // Input transfer: one raw byte of the header field area
    typedef struct packed {
        logic [7:0] data_byte;
        logic       starts_message;
    } in_item_t;

    // Result transfer: one content byte, end-of-field mark or error
    typedef struct packed {
        logic [2:0] field_kind;
        logic [7:0] content_byte;
        logic       byte_valid;
        logic       field_last;
    } out_item_t;

    // Result handed from the parser core to the output buffer
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_push_t;

    // Field type bytes
    localparam logic [7:0] TYPE_DESTINATION = 8'h06;
    localparam logic [7:0] TYPE_PATH        = 8'h01;
    localparam logic [7:0] TYPE_INTERFACE   = 8'h02;
    localparam logic [7:0] TYPE_METHOD      = 8'h03;
    localparam logic [7:0] TYPE_SIGNATURE   = 8'h09;

    // Result kinds
    localparam logic [2:0] KIND_DESTINATION = 3'd0;
    localparam logic [2:0] KIND_PATH        = 3'd1;
    localparam logic [2:0] KIND_INTERFACE   = 3'd2;
    localparam logic [2:0] KIND_METHOD      = 3'd3;
    localparam logic [2:0] KIND_PARAM       = 3'd4;
    localparam logic [2:0] KIND_ERROR       = 3'd5;

    // Parser phases
    localparam logic [2:0] PH_TYPE     = 3'd0;
    localparam logic [2:0] PH_STR_HDR  = 3'd1;
    localparam logic [2:0] PH_STR_BODY = 3'd2;
    localparam logic [2:0] PH_PAD      = 3'd3;
    localparam logic [2:0] PH_SIG_HDR  = 3'd4;
    localparam logic [2:0] PH_PAR_LEN  = 3'd5;
    localparam logic [2:0] PH_PAR_BODY = 3'd6;
    localparam logic [2:0] PH_ERROR    = 3'd7;

    // Header offsets
    localparam logic [31:0] STR_LEN_FIRST = 32'd4;
    localparam logic [31:0] STR_HDR_LAST  = 32'd7;
    localparam logic [31:0] SIG_COUNT_POS = 32'd4;
    localparam logic [8:0]  SIG_BLOCK_ADD = 9'd13;  // 6 fixed bytes plus round-up to 8

endpackage

/* hdl/mhfp_core.sv */
// Parser core of the message header field parser.
// Holds the parse state and computes the next state and the result for one byte.
// Depends on mhfp_pkg.
module mhfp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  mhfp_pkg::in_item_t item,
    output mhfp_pkg::res_push_t push
);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  params_reg, params_next;

    logic [7:0]  b;
    logic [2:0]  phase_eff;
    logic [31:0] p;
    logic [31:0] pos_dec;
    logic [31:0] sig_len;
    logic [7:0]  params_dec;
    mhfp_pkg::res_push_t res;

    assign b         = item.data_byte;
    assign phase_eff = item.starts_message ? mhfp_pkg::PH_TYPE : phase_reg;
    assign p         = pos_reg + 32'd1;
    assign pos_dec   = (pos_reg != 32'd0) ? pos_reg - 32'd1 : pos_reg;
    assign sig_len   = {23'd0, (9'(b) + mhfp_pkg::SIG_BLOCK_ADD) & 9'h1F8};
    assign params_dec = (params_reg != 8'd0) ? params_reg - 8'd1 : params_reg;

    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        params_next = params_reg;
        res         = '0;

        unique case (phase_eff)
            mhfp_pkg::PH_TYPE: begin
                pos_next = 32'd0;
                len_next = 32'd0;
                unique case (b)
                    mhfp_pkg::TYPE_DESTINATION: begin
                        kind_next  = mhfp_pkg::KIND_DESTINATION;
                        phase_next = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_PATH: begin
                        kind_next  = mhfp_pkg::KIND_PATH;
                        phase_next = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_INTERFACE: begin
                        kind_next  = mhfp_pkg::KIND_INTERFACE;
                        phase_next = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_METHOD: begin
                        kind_next  = mhfp_pkg::KIND_METHOD;
                        phase_next = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_SIGNATURE: begin
                        kind_next   = mhfp_pkg::KIND_PARAM;
                        params_next = 8'd0;
                        phase_next  = mhfp_pkg::PH_SIG_HDR;
                    end
                    default: begin
                        phase_next           = mhfp_pkg::PH_ERROR;
                        res.valid            = 1'b1;
                        res.item.field_kind  = mhfp_pkg::KIND_ERROR;
                    end
                endcase
            end
            mhfp_pkg::PH_STR_HDR: begin
                pos_next = p;
                if (p >= mhfp_pkg::STR_LEN_FIRST && p <= mhfp_pkg::STR_HDR_LAST) begin
                    // little-endian length, offset 4 lands in lane 0
                    len_next[{p[1:0], 3'b000} +: 8] = len_reg[{p[1:0], 3'b000} +: 8] | b;
                end
                if (p >= mhfp_pkg::STR_HDR_LAST) begin
                    phase_next = mhfp_pkg::PH_STR_BODY;
                    pos_next   = 32'd0;
                end
            end
            mhfp_pkg::PH_STR_BODY: begin
                res.valid           = 1'b1;
                res.item.field_kind = kind_reg;
                if (pos_reg < len_reg) begin
                    pos_next              = p;
                    res.item.content_byte = b;
                    res.item.byte_valid   = 1'b1;
                end else begin
                    // padding left after the nul so the field ends on 8 bytes
                    pos_next            = {29'd0, 3'd7 - len_reg[2:0]};
                    phase_next          = (len_reg[2:0] != 3'd7) ? mhfp_pkg::PH_PAD
                                                                 : mhfp_pkg::PH_TYPE;
                    res.item.field_last = 1'b1;
                end
            end
            mhfp_pkg::PH_PAD: begin
                pos_next = pos_dec;
                if (pos_dec == 32'd0) begin
                    phase_next = mhfp_pkg::PH_TYPE;
                end
            end
            mhfp_pkg::PH_SIG_HDR: begin
                logic [31:0] blk_len;
                logic [7:0]  cnt;
                blk_len  = len_reg;
                cnt      = params_reg;
                pos_next = p;
                if (p == mhfp_pkg::SIG_COUNT_POS) begin
                    cnt         = b;
                    blk_len     = sig_len;
                    params_next = b;
                    len_next    = sig_len;
                end
                if (p >= mhfp_pkg::SIG_COUNT_POS && (p + 32'd1) >= blk_len) begin
                    if (cnt != 8'd0) begin
                        phase_next = mhfp_pkg::PH_PAR_LEN;
                        pos_next   = 32'd0;
                        len_next   = 32'd0;
                    end else begin
                        phase_next = mhfp_pkg::PH_TYPE;
                    end
                end
            end
            mhfp_pkg::PH_PAR_LEN: begin
                len_next[{pos_reg[1:0], 3'b000} +: 8] =
                    len_reg[{pos_reg[1:0], 3'b000} +: 8] | b;
                pos_next = p;
                if (pos_reg[1:0] == 2'd3) begin
                    phase_next = mhfp_pkg::PH_PAR_BODY;
                    pos_next   = 32'd0;
                end
            end
            mhfp_pkg::PH_PAR_BODY: begin
                res.valid           = 1'b1;
                res.item.field_kind = mhfp_pkg::KIND_PARAM;
                if (pos_reg < len_reg) begin
                    pos_next              = p;
                    res.item.content_byte = b;
                    res.item.byte_valid   = 1'b1;
                end else begin
                    params_next         = params_dec;
                    res.item.field_last = 1'b1;
                    if (params_dec != 8'd0) begin
                        phase_next = mhfp_pkg::PH_PAR_LEN;
                        pos_next   = 32'd0;
                        len_next   = 32'd0;
                    end else begin
                        phase_next = mhfp_pkg::PH_TYPE;
                    end
                end
            end
            mhfp_pkg::PH_ERROR: begin
                // drop bytes until the next message start
            end
        endcase
    end

    assign push.valid = accept & res.valid;
    assign push.item  = res.item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mhfp_pkg::PH_TYPE;
            kind_reg   <= 3'd0;
            pos_reg    <= 32'd0;
            len_reg    <= 32'd0;
            params_reg <= 8'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            params_reg <= params_next;
        end
    end

    a_error_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !item.starts_message && phase_reg == mhfp_pkg::PH_ERROR |-> !push.valid)
        else $error("result produced while dropping bytes after an unknown type");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == mhfp_pkg::PH_ERROR && !(accept && item.starts_message)
        |=> phase_reg == mhfp_pkg::PH_ERROR)
        else $error("left error phase without a message start");

    a_error_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid && push.item.field_kind == mhfp_pkg::KIND_ERROR
        |=> phase_reg == mhfp_pkg::PH_ERROR)
        else $error("error result without entering error phase");

endmodule

/* hdl/mhfp_obuf.sv */
// Output buffer of the message header field parser: result register plus skid stage.
// Lets the core keep taking bytes while a result waits on the result channel.
// Depends on mhfp_pkg.
module mhfp_obuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  mhfp_pkg::res_push_t push,
    output logic                in_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output mhfp_pkg::out_item_t m_data
);

    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    mhfp_pkg::out_item_t main_reg, main_next;
    mhfp_pkg::out_item_t skid_reg, skid_next;
    logic                drain;

    assign drain    = main_valid_reg & m_ready;
    assign in_ready = ~skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (drain) begin
            main_valid_next = 1'b0;
        end
        if (skid_valid_reg) begin
            // advance the skid entry once the head transfer goes out
            if (drain) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push.valid) begin
            if (!main_valid_reg || drain) begin
                main_next       = push.item;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push.item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !skid_valid_reg)
        else $error("result pushed into a full output buffer");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && drain |=> main_valid_reg && main_reg == $past(skid_reg))
        else $error("skid entry not advanced in order");

endmodule

/* hdl/message_header_field_parser.sv */
// Top level of the message header field parser.
// Instantiates the parser core (mhfp_core) and the output buffer (mhfp_obuf); uses mhfp_pkg.
//
//   channel   ports                      payload
//   input     s_valid s_ready s_data     in_item_t: data_byte, starts_message
//   result    m_valid m_ready m_data     out_item_t: field_kind, content_byte,
//                                                    byte_valid, field_last
//
// One byte is taken per cycle while s_ready is high; its result, if any, is
// registered in the output buffer and appears on the result channel from there.
// Reset (aresetn low, synchronous) puts the parser in the expect-type phase
// and empties the output buffer.
// A two-entry output buffer absorbs a stall on the result channel; s_ready
// drops only while both entries are held.
module message_header_field_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mhfp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mhfp_pkg::out_item_t m_data
);

    logic                accept;
    mhfp_pkg::res_push_t push;

    assign accept = s_valid & s_ready;

    mhfp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .push    (push)
    );

    mhfp_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* sim/mhfp_field_checker.sv */
// Field checker for the message header field parser test bench.
// Watches both channels, predicts each result from the accepted bytes and compares in order.
// Depends on mhfp_pkg.
module mhfp_field_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mhfp_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mhfp_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state as predicted from the accepted bytes
    logic [2:0]  phase;
    logic [2:0]  kind;
    logic [31:0] pos;
    logic [31:0] flen;
    logic [7:0]  params_left;

    mhfp_pkg::out_item_t content_q[$];

    function automatic void emit_content(logic [2:0] k, logic [7:0] b, logic v, logic l);
        mhfp_pkg::out_item_t r;
        r.field_kind   = k;
        r.content_byte = b;
        r.byte_valid   = v;
        r.field_last   = l;
        content_q.push_back(r);
    endfunction

    function automatic void next_param_or_type();
        if (params_left != 8'd0) begin
            phase = mhfp_pkg::PH_PAR_LEN;
            pos   = 32'd0;
            flen  = 32'd0;
        end else begin
            phase = mhfp_pkg::PH_TYPE;
        end
    endfunction

    function automatic void parse_byte(mhfp_pkg::in_item_t it);
        logic [31:0] p;
        logic [31:0] b32;
        b32 = {24'd0, it.data_byte};
        if (it.starts_message)
            phase = mhfp_pkg::PH_TYPE;
        case (phase)
            mhfp_pkg::PH_TYPE: begin
                pos  = 32'd0;
                flen = 32'd0;
                case (it.data_byte)
                    mhfp_pkg::TYPE_DESTINATION: begin
                        kind  = mhfp_pkg::KIND_DESTINATION;
                        phase = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_PATH: begin
                        kind  = mhfp_pkg::KIND_PATH;
                        phase = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_INTERFACE: begin
                        kind  = mhfp_pkg::KIND_INTERFACE;
                        phase = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_METHOD: begin
                        kind  = mhfp_pkg::KIND_METHOD;
                        phase = mhfp_pkg::PH_STR_HDR;
                    end
                    mhfp_pkg::TYPE_SIGNATURE: begin
                        kind        = mhfp_pkg::KIND_PARAM;
                        params_left = 8'd0;
                        phase       = mhfp_pkg::PH_SIG_HDR;
                    end
                    default: begin
                        phase = mhfp_pkg::PH_ERROR;
                        emit_content(mhfp_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0);
                    end
                endcase
            end
            mhfp_pkg::PH_STR_HDR: begin
                pos = pos + 32'd1;
                p   = pos;
                if (p >= mhfp_pkg::STR_LEN_FIRST && p <= mhfp_pkg::STR_HDR_LAST)
                    flen = flen | (b32 << (8 * (p - mhfp_pkg::STR_LEN_FIRST)));
                if (p >= mhfp_pkg::STR_HDR_LAST) begin
                    phase = mhfp_pkg::PH_STR_BODY;
                    pos   = 32'd0;
                end
            end
            mhfp_pkg::PH_STR_BODY: begin
                if (pos < flen) begin
                    pos = pos + 32'd1;
                    emit_content(kind, it.data_byte, 1'b1, 1'b0);
                end else begin
                    // the closing byte ends the field whatever it holds
                    pos   = 32'd7 - {29'd0, flen[2:0]};
                    phase = (pos != 32'd0) ? mhfp_pkg::PH_PAD : mhfp_pkg::PH_TYPE;
                    emit_content(kind, 8'd0, 1'b0, 1'b1);
                end
            end
            mhfp_pkg::PH_PAD: begin
                if (pos != 32'd0)
                    pos = pos - 32'd1;
                if (pos == 32'd0)
                    phase = mhfp_pkg::PH_TYPE;
            end
            mhfp_pkg::PH_SIG_HDR: begin
                pos = pos + 32'd1;
                p   = pos;
                if (p == mhfp_pkg::SIG_COUNT_POS) begin
                    params_left = it.data_byte;
                    // six fixed bytes plus the count, rounded up to 8
                    flen = (b32 + 32'd13) & 32'hFFFF_FFF8;
                end
                if (p >= mhfp_pkg::SIG_COUNT_POS && p + 32'd1 >= flen)
                    next_param_or_type();
            end
            mhfp_pkg::PH_PAR_LEN: begin
                p    = {30'd0, pos[1:0]};
                flen = flen | (b32 << (8 * p));
                pos  = pos + 32'd1;
                if (p == 32'd3) begin
                    phase = mhfp_pkg::PH_PAR_BODY;
                    pos   = 32'd0;
                end
            end
            mhfp_pkg::PH_PAR_BODY: begin
                if (pos < flen) begin
                    pos = pos + 32'd1;
                    emit_content(mhfp_pkg::KIND_PARAM, it.data_byte, 1'b1, 1'b0);
                end else begin
                    if (params_left != 8'd0)
                        params_left = params_left - 8'd1;
                    next_param_or_type();
                    emit_content(mhfp_pkg::KIND_PARAM, 8'd0, 1'b0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_result(mhfp_pkg::out_item_t got);
        mhfp_pkg::out_item_t want;
        if (content_q.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
                $display("%0t: unexpected result: kind %0d byte %02h valid %b last %b",
                         $time, got.field_kind, got.content_byte, got.byte_valid,
                         got.field_last);
        end else begin
            want = content_q.pop_front();
            if (got.field_kind !== want.field_kind || got.content_byte !== want.content_byte ||
                got.byte_valid !== want.byte_valid || got.field_last !== want.field_last) begin
                fail_count = fail_count + 1;
                if (fail_count <= 10)
                    $display("%0t: expected %0d/%02h/%b/%b got %0d/%02h/%b/%b",
                             $time, want.field_kind, want.content_byte, want.byte_valid,
                             want.field_last, got.field_kind, got.content_byte,
                             got.byte_valid, got.field_last);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase       = mhfp_pkg::PH_TYPE;
            kind        = mhfp_pkg::KIND_DESTINATION;
            pos         = 32'd0;
            flen        = 32'd0;
            params_left = 8'd0;
            content_q.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (s_valid && s_ready)
                parse_byte(s_data);
        end
        pending_count = content_q.size();
    end

endmodule

/* sim/message_header_field_parser_test.sv */
// Test bench top for the message header field parser.
// Builds byte streams of header fields, drives them with bursts and result-side stalls,
// and gives the verdict; depends on mhfp_pkg, message_header_field_parser and mhfp_field_checker.
module message_header_field_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mhfp_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mhfp_pkg::out_item_t m_data;
    int                  fail_count;
    int                  pending_count;

    mhfp_pkg::in_item_t  stream_q[$];
    int                  burst_left    = 0;
    int                  counted_bytes = 0;

    message_header_field_parser DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mhfp_field_checker field_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("** message_header_field_parser: FAILED **");
        $finish;
    end

    // Result side: stretches of always-ready, random, mostly-stalled and periodic stalls
    initial begin
        int mode;
        int span;
        int period;
        int on_cycles;
        int n;
        forever begin
            mode      = $urandom_range(0, 3);
            span      = $urandom_range(8, 80);
            period    = $urandom_range(2, 9);
            on_cycles = $urandom_range(1, period - 1);
            for (n = 0; n < span; n++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((n % period) < on_cycles);
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void put_byte(logic [7:0] b, logic first);
        mhfp_pkg::in_item_t it;
        it.data_byte      = b;
        it.starts_message = first;
        stream_q.push_back(it);
    endfunction

    function automatic void put_junk(int count);
        int k;
        for (k = 0; k < count; k++)
            put_byte(rand_byte(), 1'b0);
    endfunction

    function automatic void put_length(logic [31:0] len);
        int k;
        for (k = 0; k < 4; k++)
            put_byte(len[8*k +: 8], 1'b0);
    endfunction

    // whole = 0 stops after the length, for lengths too big to send
    function automatic void put_string_field(logic [7:0] code, logic [31:0] len, logic first,
                                             logic whole);
        put_byte(code, first);
        put_junk(3);
        put_length(len);
        if (whole) begin
            put_junk(int'(len));
            put_junk(1);
            put_junk(7 - int'(len[2:0]));
        end
    endfunction

    function automatic void put_sig_header(int count, logic first);
        put_byte(mhfp_pkg::TYPE_SIGNATURE, first);
        put_junk(3);
        put_byte(8'(count), 1'b0);
        put_junk((count + 13) / 8 * 8 - 5);
    endfunction

    function automatic void put_param(logic [31:0] len, logic whole);
        put_length(len);
        if (whole)
            put_junk(int'(len) + 1);
    endfunction

    function automatic void put_signature(int count, int max_len, logic first);
        int k;
        put_sig_header(count, first);
        for (k = 0; k < count; k++)
            put_param(32'($urandom_range(0, max_len)), 1'b1);
    endfunction

    function automatic void put_any_field(logic first);
        int          sel;
        logic [31:0] len;
        sel = $urandom_range(0, 4);
        len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(13, 40))
                                          : 32'($urandom_range(0, 12));
        case (sel)
            0: put_string_field(mhfp_pkg::TYPE_DESTINATION, len, first, 1'b1);
            1: put_string_field(mhfp_pkg::TYPE_PATH, len, first, 1'b1);
            2: put_string_field(mhfp_pkg::TYPE_INTERFACE, len, first, 1'b1);
            3: put_string_field(mhfp_pkg::TYPE_METHOD, len, first, 1'b1);
            default: put_signature(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                               : $urandom_range(0, 4),
                                   10, first);
        endcase
    endfunction

    task automatic send_item(input mhfp_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send the first keep bytes of the built stream and drop the rest
    task automatic send_stream(input int keep);
        int k;
        for (k = 0; k < stream_q.size() && k < keep; k++)
            send_item(stream_q[k]);
        counted_bytes = counted_bytes + k;
        stream_q.delete();
    endtask

    initial begin
        logic [7:0] bad_codes [6];
        logic [7:0] code;
        int         choice;
        int         nfields;
        int         f;
        int         n;

        bad_codes = '{8'h00, 8'hFF, 8'h04, 8'h05, 8'h07, 8'h08};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // every field type, padding of 7, 0 and 6 bytes, empty string, empty signature
        put_string_field(mhfp_pkg::TYPE_DESTINATION, 32'd0, 1'b1, 1'b1);
        put_string_field(mhfp_pkg::TYPE_PATH, 32'd7, 1'b0, 1'b1);
        put_string_field(mhfp_pkg::TYPE_INTERFACE, 32'd8, 1'b0, 1'b1);
        put_string_field(mhfp_pkg::TYPE_METHOD, 32'd1, 1'b0, 1'b1);
        put_signature(0, 0, 1'b0);
        put_signature(2, 6, 1'b0);
        put_signature(3, 3, 1'b0);
        send_stream(stream_q.size());

        // widest parameter count: full header block, a few empty parameters, then restart
        put_signature(255, 0, 1'b1);
        send_stream(284);
        put_string_field(mhfp_pkg::TYPE_METHOD, 32'd15, 1'b1, 1'b1);
        send_stream(stream_q.size());

        // unknown type codes; later bytes are dropped, type codes among them too
        foreach (bad_codes[i]) begin
            put_byte(bad_codes[i], 1'b1);
            put_byte(mhfp_pkg::TYPE_PATH, 1'b0);
            put_junk(4);
            send_stream(stream_q.size());
        end

        // unknown type after a complete field, then unknown types on message starts
        put_string_field(mhfp_pkg::TYPE_INTERFACE, 32'd4, 1'b1, 1'b1);
        put_byte(8'h0A, 1'b0);
        put_junk(6);
        put_byte(8'h80, 1'b1);
        put_byte(8'h7F, 1'b1);
        send_stream(stream_q.size());

        // huge lengths, cut off by the next message start
        put_string_field(mhfp_pkg::TYPE_DESTINATION, 32'hFFFF_FFFF, 1'b1, 1'b0);
        put_junk(20);
        send_stream(stream_q.size());
        put_string_field(mhfp_pkg::TYPE_PATH, 32'h8040_2011, 1'b1, 1'b0);
        put_junk(9);
        send_stream(stream_q.size());
        put_sig_header(1, 1'b1);
        put_param(32'hFFFF_FFFF, 1'b0);
        put_junk(12);
        send_stream(stream_q.size());

        // restart inside string header, body, padding, signature header, parameter length
        put_string_field(mhfp_pkg::TYPE_METHOD, 32'd3, 1'b1, 1'b1);
        send_stream(5);
        put_string_field(mhfp_pkg::TYPE_PATH, 32'd10, 1'b1, 1'b1);
        send_stream(14);
        put_string_field(mhfp_pkg::TYPE_PATH, 32'd2, 1'b1, 1'b1);
        send_stream(stream_q.size() - 2);
        put_signature(4, 2, 1'b1);
        send_stream(6);
        put_signature(2, 3, 1'b1);
        send_stream(10);

        // random messages: mostly well formed, some cut short, some errors and noise
        while (counted_bytes < 850) begin
            choice = $urandom_range(0, 19);
            if (choice < 14) begin
                nfields = $urandom_range(1, 4);
                for (f = 0; f < nfields; f++)
                    put_any_field(f == 0);
                send_stream(stream_q.size());
            end else if (choice < 17) begin
                put_any_field(1'b1);
                put_any_field(1'b0);
                send_stream($urandom_range(1, stream_q.size()));
            end else if (choice < 19) begin
                do code = rand_byte();
                while (code == mhfp_pkg::TYPE_DESTINATION || code == mhfp_pkg::TYPE_PATH ||
                       code == mhfp_pkg::TYPE_INTERFACE || code == mhfp_pkg::TYPE_METHOD ||
                       code == mhfp_pkg::TYPE_SIGNATURE);
                put_byte(code, 1'b1);
                put_junk($urandom_range(0, 10));
                send_stream(stream_q.size());
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) put_byte(rand_byte(), ($urandom_range(0, 3) == 0));
                send_stream(stream_q.size());
            end
        end
        s_valid <= 1'b0;

        n = 0;
        while (pending_count != 0 && n < 5000) begin
            @(negedge aclk);
            n++;
        end
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("** message_header_field_parser: PASSED **");
        end else begin
            $display("** message_header_field_parser: FAILED **");
        end
        $finish;
    end

endmodule
